>>> src/load_store_align_merge_macros.svh
// assertion macros for the load/store align and merge block
`ifndef LOAD_STORE_ALIGN_MERGE_MACROS_SVH
`define LOAD_STORE_ALIGN_MERGE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define LSAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LSAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSAM_ASSERT_NOW(label, ante, cons, msg)
`define LSAM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/lsam_pkg.sv
`timescale 1ns / 1ps

package lsam_pkg;

  // access kinds
  localparam logic [4:0] K_LB  = 5'd0;
  localparam logic [4:0] K_LBU = 5'd1;
  localparam logic [4:0] K_LH  = 5'd2;
  localparam logic [4:0] K_LHU = 5'd3;
  localparam logic [4:0] K_LW  = 5'd4;
  localparam logic [4:0] K_LWU = 5'd5;
  localparam logic [4:0] K_LD  = 5'd6;
  localparam logic [4:0] K_SB  = 5'd7;
  localparam logic [4:0] K_SH  = 5'd8;
  localparam logic [4:0] K_SW  = 5'd9;
  localparam logic [4:0] K_SD  = 5'd10;
  localparam logic [4:0] K_LWL = 5'd11;
  localparam logic [4:0] K_LWR = 5'd12;
  localparam logic [4:0] K_LDL = 5'd13;
  localparam logic [4:0] K_LDR = 5'd14;
  localparam logic [4:0] K_SWL = 5'd15;
  localparam logic [4:0] K_SWR = 5'd16;
  localparam logic [4:0] K_SDL = 5'd17;
  localparam logic [4:0] K_SDR = 5'd18;

  // memory write sizes
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_DWORD = 2'd3;

  localparam logic [31:0] WORD_ONES  = 32'hFFFF_FFFF;
  localparam logic [63:0] DWORD_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] address;
    logic [4:0]  reg_index;
    logic [63:0] reg_value;
    logic [63:0] mem_value;
  } in_item_t;

  typedef struct packed {
    logic        reg_write;
    logic [63:0] reg_result;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic [63:0] mem_data;
  } out_item_t;

  // register side of one access
  typedef struct packed {
    logic        write;
    logic [63:0] result;
  } lsam_load_t;

  // memory side of one access
  typedef struct packed {
    logic        write;
    logic [31:0] address;
    logic [1:0]  size;
    logic [63:0] data;
  } lsam_store_t;

  function automatic logic [63:0] sext32(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

endpackage

>>> src/lsam_load.sv
`timescale 1ns / 1ps

module lsam_load import lsam_pkg::*; (
  input  logic [4:0]  kind,
  input  logic [2:0]  offset,
  input  logic [4:0]  reg_index,
  input  logic [63:0] reg_value,
  input  logic [63:0] mem_value,
  output lsam_load_t  load
);

  logic [1:0]  o4;
  logic [1:0]  k4;
  logic [2:0]  k8;
  logic [4:0]  sh_o4;
  logic [4:0]  sh_k4;
  logic [5:0]  sh_o8;
  logic [5:0]  sh_k8;
  logic [31:0] r32;
  logic [31:0] m32;
  logic [31:0] lwl_word;
  logic [31:0] lwr_word;
  logic [63:0] ldl_dword;
  logic [63:0] ldr_dword;
  logic        is_load;
  logic [63:0] result;

  // byte offsets within word and doubleword, and their complements
  assign o4    = offset[1:0];
  assign k4    = ~o4;
  assign k8    = ~offset;
  assign sh_o4 = {o4, 3'b000};
  assign sh_k4 = {k4, 3'b000};
  assign sh_o8 = {offset, 3'b000};
  assign sh_k8 = {k8, 3'b000};
  assign r32   = reg_value[31:0];
  assign m32   = mem_value[31:0];

  // left/right merges: keep register bytes the memory bytes do not cover
  assign lwl_word  = (r32 & ~(WORD_ONES << sh_k4)) | (m32 << sh_k4);
  assign lwr_word  = (r32 & ~(WORD_ONES >> sh_o4)) | (m32 >> sh_o4);
  assign ldl_dword = (reg_value & ~(DWORD_ONES << sh_k8)) | (mem_value << sh_k8);
  assign ldr_dword = (reg_value & ~(DWORD_ONES >> sh_o8)) | (mem_value >> sh_o8);

  // kind decode and extension
  always_comb begin
    is_load = 1'b1;
    result  = '0;
    unique case (kind)
      K_LB:  result = {{56{mem_value[7]}}, mem_value[7:0]};
      K_LBU: result = {56'd0, mem_value[7:0]};
      K_LH:  result = {{48{mem_value[15]}}, mem_value[15:0]};
      K_LHU: result = {48'd0, mem_value[15:0]};
      K_LW:  result = sext32(m32);
      K_LWU: result = {32'd0, m32};
      K_LD:  result = mem_value;
      K_LWL: result = sext32(lwl_word);
      K_LWR: begin
        // aligned case loads the whole word sign-extended, else upper half clears
        if (o4 == 2'd0) begin
          result = sext32(m32);
        end else begin
          result = {32'd0, lwr_word};
        end
      end
      K_LDL: result = ldl_dword;
      K_LDR: result = ldr_dword;
      default: begin
        is_load = 1'b0;
        result  = '0;
      end
    endcase
  end

  // register zero is never written
  always_comb begin
    load.write  = is_load && (reg_index != 5'd0);
    load.result = load.write ? result : '0;
  end

endmodule

>>> src/lsam_store.sv
`timescale 1ns / 1ps

module lsam_store import lsam_pkg::*; (
  input  logic [4:0]  kind,
  input  logic [31:0] address,
  input  logic [63:0] reg_value,
  input  logic [63:0] mem_value,
  output lsam_store_t store
);

  logic [1:0]  o4;
  logic [1:0]  k4;
  logic [2:0]  k8;
  logic [4:0]  sh_o4;
  logic [4:0]  sh_k4;
  logic [5:0]  sh_o8;
  logic [5:0]  sh_k8;
  logic [31:0] r32;
  logic [31:0] m32;
  logic [31:0] swl_word;
  logic [31:0] swr_word;
  logic [63:0] sdl_dword;
  logic [63:0] sdr_dword;
  logic [31:0] addr_w;
  logic [31:0] addr_d;

  assign o4    = address[1:0];
  assign k4    = ~o4;
  assign k8    = ~address[2:0];
  assign sh_o4 = {o4, 3'b000};
  assign sh_k4 = {k4, 3'b000};
  assign sh_o8 = {address[2:0], 3'b000};
  assign sh_k8 = {k8, 3'b000};
  assign r32   = reg_value[31:0];
  assign m32   = mem_value[31:0];

  // partial stores: old memory bytes outside the written span survive
  assign swl_word  = (m32 & ~(WORD_ONES >> sh_k4)) | (r32 >> sh_k4);
  assign swr_word  = (m32 & ~(WORD_ONES << sh_o4)) | (r32 << sh_o4);
  assign sdl_dword = (mem_value & ~(DWORD_ONES >> sh_k8)) | (reg_value >> sh_k8);
  assign sdr_dword = (mem_value & ~(DWORD_ONES << sh_o8)) | (reg_value << sh_o8);

  assign addr_w = {address[31:2], 2'b00};
  assign addr_d = {address[31:3], 3'b000};

  // kind decode
  always_comb begin
    store = '0;
    unique case (kind)
      K_SB: begin
        store.write   = 1'b1;
        store.address = address;
        store.size    = SIZE_BYTE;
        store.data    = {56'd0, reg_value[7:0]};
      end
      K_SH: begin
        store.write   = 1'b1;
        store.address = address;
        store.size    = SIZE_HALF;
        store.data    = {48'd0, reg_value[15:0]};
      end
      K_SW: begin
        store.write   = 1'b1;
        store.address = address;
        store.size    = SIZE_WORD;
        store.data    = {32'd0, r32};
      end
      K_SD: begin
        store.write   = 1'b1;
        store.address = address;
        store.size    = SIZE_DWORD;
        store.data    = reg_value;
      end
      K_SWL: begin
        store.write   = 1'b1;
        store.address = addr_w;
        store.size    = SIZE_WORD;
        store.data    = {32'd0, swl_word};
      end
      K_SWR: begin
        store.write   = 1'b1;
        store.address = addr_w;
        store.size    = SIZE_WORD;
        store.data    = {32'd0, swr_word};
      end
      K_SDL: begin
        store.write   = 1'b1;
        store.address = addr_d;
        store.size    = SIZE_DWORD;
        store.data    = sdl_dword;
      end
      K_SDR: begin
        store.write   = 1'b1;
        store.address = addr_d;
        store.size    = SIZE_DWORD;
        store.data    = sdr_dword;
      end
      default: store = '0;
    endcase
  end

endmodule

>>> src/load_store_align_merge.sv
`timescale 1ns / 1ps
`include "load_store_align_merge_macros.svh"

// Load/store align and merge for a 64-bit MIPS core. Each item
// carries the access kind, byte address, register number and content, and
// the data read from memory; one result item comes back with the new register
// value and the memory write. An item is taken every cycle when the output
// side keeps up; each item passes through the input register and then the
// result register, with the byte steering and extension between them. Plain
// accesses use the address as given; partial stores report the aligned word
// or doubleword address. Loads to register zero and unknown kinds write
// nothing, and unused result fields read zero.
module load_store_align_merge import lsam_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;
  logic        out_adv;
  lsam_load_t  load;
  lsam_store_t store;

  // handshake: each stage moves when the one after it has room
  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;

  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  lsam_load u_load (
    .kind      (s1_item_r.kind),
    .offset    (s1_item_r.address[2:0]),
    .reg_index (s1_item_r.reg_index),
    .reg_value (s1_item_r.reg_value),
    .mem_value (s1_item_r.mem_value),
    .load      (load)
  );

  lsam_store u_store (
    .kind      (s1_item_r.kind),
    .address   (s1_item_r.address),
    .reg_value (s1_item_r.reg_value),
    .mem_value (s1_item_r.mem_value),
    .store     (store)
  );

  // assemble the result item
  always_comb begin
    out_item_nxt.reg_write   = load.write;
    out_item_nxt.reg_result  = load.result;
    out_item_nxt.mem_write   = store.write;
    out_item_nxt.mem_address = store.address;
    out_item_nxt.mem_size    = store.size;
    out_item_nxt.mem_data    = store.data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // an access never writes both the register file and memory
  `LSAM_ASSERT_NOW(a_one_target, out_valid_r, !(out_item_r.reg_write && out_item_r.mem_write), "register and memory both written")
  // no memory write means clean memory fields
  `LSAM_ASSERT_NOW(a_idle_mem, out_valid_r && !out_item_r.mem_write, out_item_r.mem_address == 32'd0 && out_item_r.mem_size == SIZE_BYTE && out_item_r.mem_data == 64'd0, "memory fields set without a write")
  // a stall upstream only happens with both stages full
  `LSAM_ASSERT_NOW(a_stall_full, !in_ready, s1_valid_r && out_valid_r && !out_ready, "input stalled with room in the pipe")
  // an item leaving the input register shows up at the output
  `LSAM_ASSERT_NEXT(a_advance, s1_valid_r && out_adv, out_valid_r, "item lost between stages")

endmodule
